// ===== design/window_function_value_defines.svh =====
// assertion macros for the window function value block
// used by the port checker; expects clock and reset in the scope of use
`ifndef WINDOW_FUNCTION_VALUE_DEFINES_SVH
`define WINDOW_FUNCTION_VALUE_DEFINES_SVH

// checked only outside reset
`define WFV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define WFV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/wfv_pkg.sv =====
// shared types and constants of the window function value block
// no dependencies
package wfv_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COS_ENTRIES_DEF = 1024;
   localparam int OPCODE_W        = 3;
   localparam int POS_W           = 20;

   typedef enum logic [OPCODE_W-1:0] {
      WIN_NONE     = 3'd0,
      WIN_RECT     = 3'd1,
      WIN_TRI      = 3'd2,
      WIN_COSINE   = 3'd3,
      WIN_HANN     = 3'd4,
      WIN_BLACKMAN = 3'd5
   } kind_type;

   // quarter-wave table generation, Q30 fixed point
   localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
   localparam longint unsigned Q30_ONE      = 64'd1 << 30;
   localparam int              TAYLOR_TERMS = 10;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

endpackage

// ===== design/wfv_ifs.sv =====
// valid/ready channel interfaces of the window function value block
// depends on wfv_pkg
interface wfv_req_if import wfv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OPCODE_W-1:0]     opcode;
   logic signed [POS_W-1:0] position;

   modport source (output valid, output opcode, output position, input ready);
   modport sink   (input valid, input opcode, input position, output ready);
endinterface

interface wfv_rsp_if import wfv_pkg::*; #(
   parameter int AMP_W = FRAC_BITS_DEF + 1
) ();
   logic             valid;
   logic             ready;
   logic [AMP_W-1:0] amplitude;

   modport source (output valid, output amplitude, input ready);
   modport sink   (input valid, input amplitude, output ready);
endinterface

// ===== design/wfv_quadrant.sv =====
// folds a cosine phase (units of a quarter-table step) onto the quarter-wave table
// gives the table address and whether the value is negated; depends on wfv_pkg
module wfv_quadrant import wfv_pkg::*; #(
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF,
   parameter int PHASE_W = $clog2(8 * COS_TABLE_ENTRIES + 1),
   parameter int ADDR_W  = $clog2(COS_TABLE_ENTRIES + 1)
) (
   input  logic [PHASE_W-1:0] phase,
   output logic [ADDR_W-1:0]  addr,
   output logic               negate
);

   localparam logic [PHASE_W-1:0] N1 = PHASE_W'(COS_TABLE_ENTRIES);
   localparam logic [PHASE_W-1:0] N2 = PHASE_W'(2 * COS_TABLE_ENTRIES);
   localparam logic [PHASE_W-1:0] N3 = PHASE_W'(3 * COS_TABLE_ENTRIES);
   localparam logic [PHASE_W-1:0] N4 = PHASE_W'(4 * COS_TABLE_ENTRIES);
   localparam logic [PHASE_W-1:0] N8 = PHASE_W'(8 * COS_TABLE_ENTRIES);

   logic [PHASE_W-1:0] turn;

   // phase never exceeds two full turns
   always_comb begin
      if (phase >= N8) begin
         turn = phase - N8;
      end else if (phase >= N4) begin
         turn = phase - N4;
      end else begin
         turn = phase;
      end
   end

   always_comb begin
      if (turn < N1) begin
         addr   = ADDR_W'(turn);
         negate = 1'b0;
      end else if (turn < N2) begin
         addr   = ADDR_W'(N2 - turn);
         negate = 1'b1;
      end else if (turn < N3) begin
         addr   = ADDR_W'(turn - N2);
         negate = 1'b1;
      end else begin
         addr   = ADDR_W'(N4 - turn);
         negate = 1'b0;
      end
   end

endmodule

// ===== design/wfv_cos_rom.sv =====
// quarter-wave cosine table, two synchronous read ports with registered outputs
// contents built at elaboration from a Taylor series; depends on wfv_pkg
module wfv_cos_rom import wfv_pkg::*; #(
   parameter int FRAC_BITS         = FRAC_BITS_DEF,
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF,
   parameter int ADDR_W            = $clog2(COS_TABLE_ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ADDR_W-1:0]    addr_a,
   input  logic [ADDR_W-1:0]    addr_b,
   output logic [FRAC_BITS:0]   data_a,
   output logic [FRAC_BITS:0]   data_b
);

   typedef logic [FRAC_BITS:0] rom_type [COS_TABLE_ENTRIES+1];

   function automatic rom_type build_rom();
      rom_type         tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      for (int k = 0; k <= COS_TABLE_ENTRIES; k++) begin
         x   = (HALF_PI_Q30 * 64'(k)) / COS_TABLE_ENTRIES;
         x2  = (x * x) >> 30;
         mag = Q30_ONE;
         sum = longint'(Q30_ONE);
         for (int i = 1; i <= TAYLOR_TERMS; i++) begin
            mag = ((mag * x2) >> 30) / TAYLOR_DIV[i-1];
            if (i[0]) begin
               sum = sum - longint'(mag);
            end else begin
               sum = sum + longint'(mag);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
         end
         // round half up to the output fraction
         tab[k] = (FRAC_BITS + 1)'((sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
      end
      return tab;
   endfunction

   localparam rom_type CosRom = build_rom();

   logic [FRAC_BITS:0] data_a_ff;
   logic [FRAC_BITS:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_a_ff <= CosRom[addr_a];
         data_b_ff <= CosRom[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// ===== design/window_function_value.sv =====
// window function value generator: top level with the four-stage pipeline
// depends on wfv_pkg, wfv_ifs, wfv_quadrant and wfv_cos_rom
//
// usage
//   req carries a window kind (opcode) and a signed position with FRAC_BITS
//   fraction bits; rsp returns the unsigned amplitude, 0 to 1.0, saturated
//   kinds: none, rectangular, triangular, cosine, hann, blackman; unused
//   opcodes give 1.0, and every kind but none gives 0 outside 0 to 1.0
//   an accepted beat passes stages 1 to 4 in order; rsp.valid is the stage 4 valid
//   throughput: one beat per cycle, sustained while rsp.ready stays high
//   stage 1 works out the cosine phases, stage 2 reads both phases from the
//   quarter-wave table (two read ports, COS_TABLE_ENTRIES + 1 entries),
//   stage 3 mixes the window terms, stage 4 divides the blackman sum by 100
//   with a reciprocal multiply and holds the result beat
//   each stage moves on when the stage after it is empty or moving, so a
//   stalled receiver only fills bubbles; req.ready falls once all four
//   stages hold beats and rsp.ready is low
//   reset empties the pipeline; the table is constant and needs no clearing
module window_function_value import wfv_pkg::*; #(
   parameter int FRAC_BITS         = FRAC_BITS_DEF,
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wfv_req_if.sink   req,
   wfv_rsp_if.source rsp
);

   localparam int AmpW   = FRAC_BITS + 1;
   localparam int PhaseW = $clog2(8 * COS_TABLE_ENTRIES + 1);
   localparam int AddrW  = $clog2(COS_TABLE_ENTRIES + 1);
   localparam int TW     = (POS_W > FRAC_BITS + 2) ? POS_W : FRAC_BITS + 2;
   localparam int MW     = FRAC_BITS + 1 + PhaseW;
   localparam int PreW   = FRAC_BITS + 7;
   localparam int SW     = FRAC_BITS + 9;
   localparam int DivShift = PreW + 7;
   localparam int ProdW  = 2 * PreW + 1;

   localparam logic signed [TW-1:0] OneT    = TW'(64'd1 << FRAC_BITS);
   localparam logic [AmpW-1:0]      OneA    = AmpW'(64'd1 << FRAC_BITS);
   localparam logic [AmpW-1:0]      HalfA   = AmpW'(64'd1 << (FRAC_BITS - 1));
   localparam logic [MW-1:0]        HalfM   = MW'(64'd1 << (FRAC_BITS - 1));
   localparam logic [PhaseW-1:0]    Quarter3 = PhaseW'(3 * COS_TABLE_ENTRIES);
   localparam logic [PreW-1:0]      OneP    = PreW'(64'd1 << FRAC_BITS);
   localparam logic [PreW-1:0]      Fifty   = PreW'(50);
   localparam logic signed [SW-1:0] OneS    = SW'(64'd1 << FRAC_BITS);
   localparam logic signed [SW-1:0] BlackA  = SW'(64'd42 << FRAC_BITS);
   localparam logic signed [SW-1:0] K50     = SW'(50);
   localparam logic signed [SW-1:0] K8      = SW'(8);
   localparam logic signed [SW-1:0] K1      = SW'(1);
   // floor(x / 100) == (x * DivMul) >> DivShift for every x below 2^PreW
   localparam logic [PreW:0] DivMul = (PreW + 1)'(((64'd1 << DivShift) + 64'd99) / 64'd100);

   // handshake chain
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !valid4_ff || rsp.ready;
   assign adv3 = !valid3_ff || adv4;
   assign adv2 = !valid2_ff || adv3;
   assign adv1 = !valid1_ff || adv2;
   assign req.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= req.valid;
         if (adv2) valid2_ff <= valid1_ff;
         if (adv3) valid3_ff <= valid2_ff;
         if (adv4) valid4_ff <= valid3_ff;
      end
   end

   // stage 1: range check, phases, triangle
   logic signed [TW-1:0] t_ext;
   logic                 in_range;
   logic [AmpW-1:0]      t_u;
   logic [MW-1:0]        base;
   logic [PhaseW-1:0]    ph_cos, ph_a_in, ph_b_in;
   logic [AmpW-1:0]      tri_in;
   logic                 zero_in;

   assign t_ext    = TW'(req.position);
   assign in_range = !t_ext[TW-1] && (t_ext <= OneT);
   assign t_u      = in_range ? t_ext[FRAC_BITS:0] : '0;
   assign base     = MW'(t_u) * MW'(COS_TABLE_ENTRIES);
   assign ph_cos   = PhaseW'(((base << 1) + HalfM) >> FRAC_BITS) + Quarter3;
   assign ph_b_in  = PhaseW'(((base << 3) + HalfM) >> FRAC_BITS);
   assign ph_a_in  = (req.opcode == WIN_COSINE) ? ph_cos
                                                : PhaseW'(((base << 2) + HalfM) >> FRAC_BITS);
   assign zero_in  = (req.opcode inside {[WIN_RECT:WIN_BLACKMAN]}) && !in_range;

   always_comb begin
      if (t_u >= HalfA) begin
         tri_in = AmpW'((AmpW + 1)'(OneA - t_u) << 1);
      end else begin
         tri_in = AmpW'((AmpW + 1)'(t_u) << 1);
      end
   end

   kind_type          kind1_ff;
   logic              zero1_ff;
   logic [AmpW-1:0]   tri1_ff;
   logic [PhaseW-1:0] ph_a1_ff, ph_b1_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         kind1_ff <= kind_type'(req.opcode);
         zero1_ff <= zero_in;
         tri1_ff  <= tri_in;
         ph_a1_ff <= ph_a_in;
         ph_b1_ff <= ph_b_in;
      end
   end

   // stage 2: table read
   logic [AddrW-1:0] addr_a, addr_b;
   logic             neg_a_in, neg_b_in;
   logic [AmpW-1:0]  rom_a, rom_b;

   wfv_quadrant #(.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_quad_a (
      .phase (ph_a1_ff),
      .addr  (addr_a),
      .negate(neg_a_in)
   );

   wfv_quadrant #(.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_quad_b (
      .phase (ph_b1_ff),
      .addr  (addr_b),
      .negate(neg_b_in)
   );

   wfv_cos_rom #(
      .FRAC_BITS        (FRAC_BITS),
      .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
   ) u_cos_rom (
      .clock (clock),
      .enable(adv2),
      .addr_a(addr_a),
      .addr_b(addr_b),
      .data_a(rom_a),
      .data_b(rom_b)
   );

   kind_type        kind2_ff;
   logic            zero2_ff;
   logic [AmpW-1:0] tri2_ff;
   logic            neg_a2_ff, neg_b2_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         kind2_ff  <= kind1_ff;
         zero2_ff  <= zero1_ff;
         tri2_ff   <= tri1_ff;
         neg_a2_ff <= neg_a_in;
         neg_b2_ff <= neg_b_in;
      end
   end

   // stage 3: window terms
   logic signed [SW-1:0] c_a, c_b, hann, black;
   logic [PreW-1:0]      pre_in;
   logic                 div_in;

   assign c_a   = neg_a2_ff ? -$signed(SW'(rom_a)) : $signed(SW'(rom_a));
   assign c_b   = neg_b2_ff ? -$signed(SW'(rom_b)) : $signed(SW'(rom_b));
   assign hann  = (OneS - c_a + K1) >>> 1;
   assign black = BlackA - K50 * c_a + K8 * c_b;

   always_comb begin
      pre_in = OneP;
      div_in = 1'b0;
      if (zero2_ff) begin
         pre_in = '0;
      end else begin
         case (kind2_ff)
            WIN_RECT: pre_in = OneP;
            WIN_TRI:  pre_in = PreW'(tri2_ff);
            WIN_COSINE: begin
               pre_in = (c_a < 0) ? '0 : c_a[PreW-1:0];
            end
            WIN_HANN: pre_in = hann[PreW-1:0];
            WIN_BLACKMAN: begin
               pre_in = (black < 0) ? '0 : black[PreW-1:0];
               div_in = 1'b1;
            end
            default: pre_in = OneP;
         endcase
      end
   end

   logic [PreW-1:0] pre3_ff;
   logic            div3_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         pre3_ff <= pre_in;
         div3_ff <= div_in;
      end
   end

   // stage 4: blackman divide by 100, round half up, saturate
   logic [ProdW-1:0] prod;
   logic [PreW-1:0]  quot, val;
   logic [AmpW-1:0]  amp_in;
   logic [AmpW-1:0]  amp_ff;

   assign prod   = ProdW'(pre3_ff + Fifty) * ProdW'(DivMul);
   assign quot   = prod[DivShift +: PreW];
   assign val    = div3_ff ? quot : pre3_ff;
   assign amp_in = (val > OneP) ? OneA : val[AmpW-1:0];

   always_ff @(posedge clock) begin
      if (adv4) begin
         amp_ff <= amp_in;
      end
   end

   assign rsp.valid     = valid4_ff;
   assign rsp.amplitude = amp_ff;

endmodule

// ===== design/wfv_checker.sv =====
// port-level checks of the window function value block, bound to the top level
// depends on window_function_value_defines.svh
`include "window_function_value_defines.svh"

module wfv_checker #(
   parameter int AMP_W = 17
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [AMP_W-1:0] rsp_amplitude
);

   localparam logic [AMP_W-1:0] AmpOne = AMP_W'(64'd1 << (AMP_W - 1));

   // a waiting result beat is not withdrawn
   `WFV_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")

   // amplitude saturates at one
   `WFV_ASSERT(a_amp_range, rsp_valid |-> rsp_amplitude <= AmpOne, "amplitude above one")

   // reset empties the pipeline
   `WFV_ASSERT(a_reset_empty, $past(reset) |-> !rsp_valid, "result beat after reset")

   // a free output stage lets the whole pipeline move, so input is taken
   `WFV_ASSERT_ALWAYS(a_ready_free, !rsp_valid || rsp_ready |-> req_ready, "input stalled needlessly")

endmodule

bind window_function_value wfv_checker #(.AMP_W(FRAC_BITS + 1)) u_wfv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_amplitude(rsp.amplitude)
);

// ===== verif/testbench.sv =====
// self-checking testbench of the window function value block
// needs wfv_pkg, the channel interfaces in wfv_ifs and the window_function_value top
module testbench import wfv_pkg::*; ();

   localparam int           FRAC      = FRAC_BITS_DEF;
   localparam int           N_ENTRIES = COS_ENTRIES_DEF;
   localparam longint       UNITY     = 64'sd1 <<< FRAC;
   localparam int           AMP_W     = FRAC + 1;
   localparam int           RAND_PTS  = 500;
   localparam int           LIMIT     = 400000;
   localparam int           HOLD_LEN  = 300;
   localparam int           HOLD_AT   = 120;
   // opcodes beyond blackman behave like none
   localparam logic [OPCODE_W-1:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] KIND_UNUSED_HI = 3'd7;

   typedef struct {
      logic [OPCODE_W-1:0] kind;
      logic [POS_W-1:0]    pos;
      int                  gap_after;
      bit                  drain_first;
   } window_point_t;

   typedef struct {
      logic [OPCODE_W-1:0] kind;
      logic [POS_W-1:0]    pos;
      logic [AMP_W-1:0]    amp;
   } amp_due_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wfv_req_if req_ch ();
   wfv_rsp_if rsp_ch ();

   window_function_value DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   window_point_t sample_points[$];
   amp_due_t      amps_due[$];

   int  mismatches    = 0;
   int  amps_checked  = 0;
   int  drains        = 0;
   int  cycles        = 0;
   int  gap_left      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   bit  hold_done     = 1'b0;
   int  kind_hits [8] = '{default: 0};

   // ---------------- predictor ----------------

   // quarter-wave cosine entry k, Taylor series in Q30 rounded to FRAC bits
   function automatic longint quarter_cos(longint unsigned k);
      longint unsigned x, x2, mag, div;
      longint          sum;
      if (k > N_ENTRIES) k = 64'(N_ENTRIES);
      x   = (HALF_PI_Q30 * k) / N_ENTRIES;
      x2  = (x * x) >> 30;
      mag = Q30_ONE;
      sum = Q30_ONE;
      for (int i = 1; i <= TAYLOR_TERMS; i++) begin
         div = 64'((2 * i - 1) * (2 * i));
         mag = ((mag * x2) >> 30) / div;
         if (i % 2) sum -= longint'(mag);
         else sum += longint'(mag);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = Q30_ONE;
      return (sum + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
   endfunction

   // phase in units of a quarter-table step, one turn is 4 * N_ENTRIES
   function automatic longint phase_cos(longint unsigned p);
      longint unsigned q, r;
      p = p % (4 * N_ENTRIES);
      q = p / N_ENTRIES;
      r = p % N_ENTRIES;
      case (q)
         0: return quarter_cos(r);
         1: return -quarter_cos(N_ENTRIES - r);
         2: return -quarter_cos(r);
         default: return quarter_cos(N_ENTRIES - r);
      endcase
   endfunction

   function automatic longint unsigned turn_phase(longint t, longint unsigned mult);
      return (longint'(t) * mult + (64'd1 << (FRAC - 1))) >> FRAC;
   endfunction

   function automatic logic [AMP_W-1:0] window_amplitude(logic [OPCODE_W-1:0] kind,
                                                        logic signed [POS_W-1:0] pos);
      longint t, v, c1, c2, d;
      t = longint'(pos);
      if (kind == WIN_NONE || kind > WIN_BLACKMAN) return AMP_W'(UNITY);
      if (t < 0 || t > UNITY) return '0;
      case (kind)
         WIN_RECT: v = UNITY;
         WIN_TRI: begin
            d = 2 * t - UNITY;
            if (d < 0) d = -d;
            v = UNITY - d;
         end
         WIN_COSINE: v = phase_cos(turn_phase(t, 64'(2 * N_ENTRIES)) + 3 * N_ENTRIES);
         WIN_HANN: begin
            c1 = phase_cos(turn_phase(t, 64'(4 * N_ENTRIES)));
            v  = (UNITY - c1 + 1) >>> 1;
         end
         default: begin
            c1 = phase_cos(turn_phase(t, 64'(4 * N_ENTRIES)));
            c2 = phase_cos(turn_phase(t, 64'(8 * N_ENTRIES)));
            v  = 42 * UNITY - 50 * c1 + 8 * c2;
            if (v < 0) v = 0;
            v = (v + 50) / 100;
         end
      endcase
      if (v < 0) v = 0;
      if (v > UNITY) v = UNITY;
      return v[AMP_W-1:0];
   endfunction

   // ---------------- stimulus helpers ----------------

   // idle length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [POS_W-1:0] random_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return POS_W'($urandom_range(0, UNITY));
      if (r < 80) begin
         if ($urandom_range(0, 1)) return POS_W'(UNITY + $urandom_range(0, 8) - 4);
         return POS_W'($urandom_range(0, 8) - 4);
      end
      return POS_W'($urandom());
   endfunction

   task automatic queue_point(logic [OPCODE_W-1:0] kind, logic [POS_W-1:0] pos,
                              int gap, bit drain);
      window_point_t p;
      p.kind        = kind;
      p.pos         = pos;
      p.gap_after   = gap;
      p.drain_first = drain;
      sample_points.push_back(p);
   endtask

   // ---------------- clock, reset, stimulus and end of run ----------------

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      logic [OPCODE_W-1:0] kind;
      int                  gap;
      bit                  quiet;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;

      // directed: every kind at both ends of the window, then the corners
      for (int k = WIN_NONE; k <= KIND_UNUSED_HI; k++) begin
         queue_point(OPCODE_W'(k), POS_W'(0), 0, 1'b0);
         queue_point(OPCODE_W'(k), POS_W'(UNITY), $urandom_range(0, 2), 1'b0);
      end
      queue_point(WIN_TRI,      POS_W'(UNITY / 2), 0, 1'b0);
      queue_point(WIN_TRI,      POS_W'(1),         0, 1'b0);
      queue_point(WIN_HANN,     POS_W'(UNITY / 2), 0, 1'b0);
      queue_point(WIN_BLACKMAN, POS_W'(UNITY / 2), 0, 1'b0);
      queue_point(WIN_COSINE,   POS_W'(UNITY / 4), 0, 1'b0);
      queue_point(WIN_RECT,     20'hFFFFF,         0, 1'b0);
      queue_point(WIN_RECT,     POS_W'(UNITY + 1), 0, 1'b0);
      queue_point(WIN_BLACKMAN, 20'h80000,         0, 1'b0);
      queue_point(KIND_UNUSED_LO, 20'h7FFFF,       0, 1'b0);

      for (int i = 0; i < RAND_PTS; i++) begin
         if ($urandom_range(0, 99) < 85) kind = OPCODE_W'($urandom_range(WIN_NONE, WIN_BLACKMAN));
         else kind = OPCODE_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         // back-to-back stretches
         quiet = (i >= 100 && i < 160) || (i >= 300 && i < 340);
         gap   = (!quiet && $urandom_range(0, 99) < 40) ? idle_len() : 0;
         queue_point(kind, random_position(), gap, i == 200 || i == 380);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (sample_points.size() != 0 || req_ch.valid) @(posedge clock);
      while (amps_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("checked %0d amplitudes over all eight opcodes, positions in and out of 0..1.0",
               amps_checked);
      $display("sender drained %0d times, receiver held off %0d cycles once, %0d mismatches",
               drains, HOLD_LEN, mismatches);
      if (mismatches == 0 && amps_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d amplitudes outstanding", cycles, amps_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- driver ----------------

   always @(posedge clock) begin
      bit            fire;
      window_point_t p;
      amp_due_t      due;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         fire = req_ch.valid && req_ch.ready;
         if (fire) begin
            due.kind = req_ch.opcode;
            due.pos  = req_ch.position;
            due.amp  = window_amplitude(req_ch.opcode, req_ch.position);
            amps_due.push_back(due);
            kind_hits[req_ch.opcode]++;
         end
         if (!req_ch.valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (sample_points.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (sample_points[0].drain_first && amps_due.size() != 0) begin
               // wait for the pipeline to empty
               req_ch.valid <= 1'b0;
            end else begin
               p = sample_points.pop_front();
               if (p.drain_first) drains++;
               req_ch.valid    <= 1'b1;
               req_ch.opcode   <= p.kind;
               req_ch.position <= p.pos;
               gap_left         = p.gap_after;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      amp_due_t due;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (amps_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: amplitude %0d with nothing outstanding",
                           rsp_ch.amplitude);
            end else begin
               due = amps_due.pop_front();
               amps_checked++;
               if (rsp_ch.amplitude !== due.amp) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("amplitude mismatch kind %0d pos %0d: expected %0d got %0d",
                              due.kind, $signed(due.pos), due.amp, rsp_ch.amplitude);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && amps_checked >= HOLD_AT) begin
            // long hold-off so the pipeline fills and back-pressures req
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ((amps_checked / 80) % 3 != 1 && $urandom_range(0, 99) < 25)
               stall_left = idle_len();
         end
      end
   end

endmodule
